FILE: rtl/core/bdq_pkg.sv
// Package for the bounded deque: sizes, request and status codes, FSM states,
// inter-module structs and the ring index helper.
// No dependencies.
`default_nettype none
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int DATAW = 32;
  localparam int REQW  = 3;
  localparam int ECW   = 5;
  localparam int STW   = 2;

  typedef enum logic [REQW-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_POP_BACK   = 3'd1,
    REQ_PUSH_FRONT = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_DELETE     = 3'd4
  } req_code_t;

  typedef enum logic [STW-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_DCMP,
    S_SHRD,
    S_SHWR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDXW-1:0]  wr_addr;
    logic [DATAW-1:0] wr_data;
    logic             rd_en;
    logic [IDXW-1:0]  rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic signed [DATAW-1:0] popped_value;
    logic [ECW-1:0]          entry_count;
    status_t                 status;
  } result_t;

  // Ring slot that lies off places behind base; the sum stays below 2*DEPTH.
  function automatic logic [IDXW-1:0] slot_add(input logic [IDXW-1:0] base,
                                               input logic [CNTW-1:0] off);
    logic [IDXW:0] sum;
    sum = (IDXW+1)'(base) + (IDXW+1)'(off);
    if (sum >= (IDXW+1)'(DEPTH)) begin
      sum = sum - (IDXW+1)'(DEPTH);
    end
    return sum[IDXW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bdq_ifs.sv
// Valid/ready channel interfaces for the deque request and result beats.
// Depends on bdq_pkg.
`default_nettype none
interface bdq_req_if;
  logic                             valid;
  logic                             ready;
  logic [bdq_pkg::REQW-1:0]         req_type;
  logic signed [bdq_pkg::DATAW-1:0] item_value;

  modport source(output valid, output req_type, output item_value, input ready);
  modport sink(input valid, input req_type, input item_value, output ready);
endinterface

interface bdq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [bdq_pkg::DATAW-1:0] popped_value;
  logic [bdq_pkg::ECW-1:0]          entry_count;
  logic [bdq_pkg::STW-1:0]          status;

  modport source(output valid, output popped_value, output entry_count,
                 output status, input ready);
  modport sink(input valid, input popped_value, input entry_count,
               input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bdq_store.sv
// Ring entry store: one write port, one read port with registered read data.
// Depends on bdq_pkg.
`default_nettype none
module bdq_store (
  input  wire logic                         clk,
  input  wire bdq_pkg::mem_req_t            mem_req,
  output logic [bdq_pkg::DATAW-1:0]         rd_data
);

  logic [bdq_pkg::DATAW-1:0] mem [bdq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bdq_ctrl.sv
// Deque sequencer: front/count registers, request decode, delete scan and
// compaction over the ring store. Depends on bdq_pkg.
`default_nettype none
module bdq_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bdq_pkg::REQW-1:0]       in_req_type,
  input  wire logic [bdq_pkg::DATAW-1:0]      in_item_value,
  output bdq_pkg::mem_req_t                   mem_req,
  input  wire logic [bdq_pkg::DATAW-1:0]      rd_data,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output bdq_pkg::result_t                    res
);

  bdq_pkg::state_t                 state_r, state_nxt;
  logic [bdq_pkg::IDXW-1:0]        front_r, front_nxt;
  logic [bdq_pkg::CNTW-1:0]        count_r, count_nxt;
  logic [bdq_pkg::CNTW-1:0]        idx_r, idx_nxt;
  logic [bdq_pkg::DATAW-1:0]       val_r, val_nxt;
  logic [bdq_pkg::DATAW-1:0]       pop_r, pop_nxt;
  bdq_pkg::status_t                stat_r, stat_nxt;
  logic                            is_full;
  logic                            is_empty;
  logic [bdq_pkg::CNTW-1:0]        idx_inc;

  assign is_full  = (count_r == bdq_pkg::CNTW'(bdq_pkg::DEPTH));
  assign is_empty = (count_r == '0);
  assign idx_inc  = idx_r + bdq_pkg::CNTW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    val_r  <= val_nxt;
    pop_r  <= pop_nxt;
    stat_r <= stat_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    pop_nxt   = pop_r;
    stat_nxt  = stat_r;
    mem_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt   = in_item_value;
          pop_nxt   = '0;
          stat_nxt  = bdq_pkg::STAT_OK;
          idx_nxt   = '0;
          state_nxt = bdq_pkg::S_RESP;
          unique case (in_req_type)
            bdq_pkg::REQ_PUSH_BACK: begin
              if (is_full) begin
                stat_nxt = bdq_pkg::STAT_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = bdq_pkg::slot_add(front_r, count_r);
                mem_req.wr_data = in_item_value;
                count_nxt       = count_r + bdq_pkg::CNTW'(1);
              end
            end
            bdq_pkg::REQ_PUSH_FRONT: begin
              if (is_full) begin
                stat_nxt = bdq_pkg::STAT_FULL;
              end else begin
                front_nxt = (front_r == '0) ? bdq_pkg::IDXW'(bdq_pkg::DEPTH - 1)
                                            : front_r - bdq_pkg::IDXW'(1);
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = front_nxt;
                mem_req.wr_data = in_item_value;
                count_nxt       = count_r + bdq_pkg::CNTW'(1);
              end
            end
            bdq_pkg::REQ_POP_BACK, bdq_pkg::REQ_POP_FRONT: begin
              if (is_empty) begin
                stat_nxt = bdq_pkg::STAT_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = (in_req_type == bdq_pkg::REQ_POP_FRONT) ? front_r :
                                  bdq_pkg::slot_add(front_r, count_r - bdq_pkg::CNTW'(1));
                idx_nxt   = (in_req_type == bdq_pkg::REQ_POP_FRONT) ? bdq_pkg::CNTW'(1)
                                                                    : '0;
                state_nxt = bdq_pkg::S_POP;
              end
            end
            bdq_pkg::REQ_DELETE: begin
              if (is_empty) begin
                stat_nxt = bdq_pkg::STAT_NOT_FOUND;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = front_r;
                state_nxt       = bdq_pkg::S_DCMP;
              end
            end
            default: ;
          endcase
        end
      end

      bdq_pkg::S_POP: begin
        // idx_r flags a front pop
        pop_nxt   = rd_data;
        count_nxt = count_r - bdq_pkg::CNTW'(1);
        if (idx_r[0]) begin
          front_nxt = bdq_pkg::slot_add(front_r, bdq_pkg::CNTW'(1));
        end
        state_nxt = bdq_pkg::S_RESP;
      end

      bdq_pkg::S_DCMP: begin
        if (rd_data == val_r) begin
          state_nxt = bdq_pkg::S_SHRD;
        end else if (idx_inc == count_r) begin
          stat_nxt  = bdq_pkg::STAT_NOT_FOUND;
          state_nxt = bdq_pkg::S_RESP;
        end else begin
          idx_nxt         = idx_inc;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = bdq_pkg::slot_add(front_r, idx_inc);
        end
      end

      bdq_pkg::S_SHRD: begin
        if (idx_inc < count_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = bdq_pkg::slot_add(front_r, idx_inc);
          state_nxt       = bdq_pkg::S_SHWR;
        end else begin
          count_nxt = count_r - bdq_pkg::CNTW'(1);
          state_nxt = bdq_pkg::S_RESP;
        end
      end

      bdq_pkg::S_SHWR: begin
        // move the entry one slot toward the front
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = bdq_pkg::slot_add(front_r, idx_r);
        mem_req.wr_data = rd_data;
        idx_nxt         = idx_inc;
        state_nxt       = bdq_pkg::S_SHRD;
      end

      bdq_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = bdq_pkg::S_IDLE;
        end
      end

      default: state_nxt = bdq_pkg::S_IDLE;
    endcase
  end

  assign res.popped_value = pop_r;
  assign res.entry_count  = bdq_pkg::ECW'(count_r);
  assign res.status       = stat_r;

endmodule
`default_nettype wire

FILE: rtl/core/bounded_deque_with_delete_top.sv
// Bounded deque with delete-first-match: top level with result output register.
// Path, accept to out beat: push, empty pop and unknown codes pass S_IDLE, S_RESP and the output
// register; a pop adds S_POP; delete adds S_DCMP per entry scanned and, on a hit, S_SHRD and
// S_SHWR per entry moved, then a final S_SHRD. One request in flight: it holds the sequencer
// until the output register (empty or out_rsp.ready) takes its reply. Reset (rst_n low, synchronous):
// queue empty, front at slot 0; store contents are kept and never read before written.
`default_nettype none
module bounded_deque_with_delete_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bdq_req_if.sink    in_req,
  bdq_rsp_if.source  out_rsp
);

  bdq_pkg::mem_req_t          mem_req;
  logic [bdq_pkg::DATAW-1:0]  rd_data;
  logic                       res_valid;
  logic                       res_ready;
  bdq_pkg::result_t           res;
  logic                       out_valid_r;
  bdq_pkg::result_t           out_data_r;

  bdq_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  bdq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_req.valid),
    .in_ready      (in_req.ready),
    .in_req_type   (in_req.req_type),
    .in_item_value (in_req.item_value),
    .mem_req       (mem_req),
    .rd_data       (rd_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.popped_value = out_data_r.popped_value;
  assign out_rsp.entry_count  = out_data_r.entry_count;
  assign out_rsp.status       = out_data_r.status;

endmodule
`default_nettype wire
